[design/pcm_sine_tone_generator_unit_macros.svh]
// Assertion macros shared by the tone generator checker.
// No dependencies; clock and reset are the top-level port names.
`ifndef PCM_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`define PCM_SINE_TONE_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSTG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSTG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pstg_pkg.sv]
// Package for the PCM sine tone generator: register indexes, reset values,
// parameter defaults and the quarter-wave sine table builder. No dependencies.
package pstg_pkg;

   localparam int unsigned MAX_CHANNELS_DEFAULT    = 8;
   localparam int unsigned PHASE_BITS_DEFAULT      = 32;
   localparam int unsigned TABLE_ADDR_BITS_DEFAULT = 10;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_PHASE_INCREMENT = 3'd0;
   localparam csr_index_type CSR_SAMPLE_BITS     = 3'd1;
   localparam csr_index_type CSR_CONTAINER_BYTES = 3'd2;
   localparam csr_index_type CSR_BIG_ENDIAN      = 3'd3;
   localparam csr_index_type CSR_UNSIGNED_OFFSET = 3'd4;
   localparam csr_index_type CSR_CHANNEL_COUNT   = 3'd5;

   localparam logic [31:0] PHASE_INCREMENT_RESET = 32'd89478485;
   localparam logic [5:0]  SAMPLE_BITS_RESET     = 6'd16;
   localparam logic [2:0]  CONTAINER_BYTES_RESET = 3'd2;
   localparam logic        BIG_ENDIAN_RESET      = 1'b0;
   localparam logic        UNSIGNED_OFFSET_RESET = 1'b0;
   localparam logic [3:0]  CHANNEL_COUNT_RESET   = 4'd2;

   // pi/2 in Q31, and the Q31 clamp limit
   localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
   localparam longint      Q31_MAX     = 64'sd2147483647;

   // Unsigned 64-bit quotient by shift and subtract; elaboration-time only.
   function automatic logic [63:0] udiv64(input logic [63:0] num,
                                          input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(pi/2 * i / 2^addr_bits) in Q31 by a truncated Taylor series.
   // Elaboration-time only; feeds the ROM constants.
   function automatic logic [30:0] quarter_sine(input int unsigned i,
                                                input int unsigned addr_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      x    = (64'(i) * HALF_PI_Q31) >> addr_bits;
      x2   = (x * x) >> 31;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
         term = udiv64((term * x2) >> 31, 64'(2 * k) * 64'(2 * k + 1));
         if ((k % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > Q31_MAX) begin
         sum = Q31_MAX;
      end
      return sum[30:0];
   endfunction

endpackage

[design/pcm_sine_tone_generator_unit.sv]
// PCM sine tone generator top level: phase accumulator, sine ROM, scaling,
// container formatting and per-channel fan-out. Depends on pstg_pkg.
//
// Each frame_tick transfer on req_ produces one audio frame: a sine sample
// from a phase accumulator (reset to a quarter turn, stepped by
// phase_increment after each frame) and a quarter-wave ROM of
// 2^TABLE_ADDR_BITS entries, scaled to sample_bits, optionally offset-binary,
// packed little- or big-endian into a 1..4 byte container with byte enables.
// The frame goes out as channel_count rsp_ transfers (channel 0 first,
// rsp_last on the final one). A tick of zero is taken and ignored. A frame
// passes the ROM read, multiply and output registers before its first rsp_
// transfer. channel_count is clamped to 1..MAX_CHANNELS; the single output
// register emits one channel per cycle while rsp_ready is high and takes
// the next frame as the current one's last channel leaves. Up to three
// frames are in flight (ROM read, multiply, output). Configuration is taken
// on csr_ every cycle (csr_ready is always high) and must only change while
// no frame is in flight; indexes beyond the register list are dropped.
module pcm_sine_tone_generator_unit #(
   parameter int unsigned MAX_CHANNELS    = pstg_pkg::MAX_CHANNELS_DEFAULT,
   parameter int unsigned PHASE_BITS      = pstg_pkg::PHASE_BITS_DEFAULT,
   parameter int unsigned TABLE_ADDR_BITS = pstg_pkg::TABLE_ADDR_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // frame tick input
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_frame_tick,
   // sample output
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_channel,
   output logic [31:0]             rsp_sample_word,
   output logic [3:0]              rsp_byte_enable,
   output logic                    rsp_last,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  pstg_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_data
);

   localparam int unsigned TABLE_SIZE = 1 << TABLE_ADDR_BITS;
   localparam int unsigned CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // ---------------------------------------------------------------------
   // Sine ROM, built at elaboration, read through a registered port
   // ---------------------------------------------------------------------
   logic [30:0] sine_rom [TABLE_SIZE];

   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
      localparam logic [30:0] ENTRY = pstg_pkg::quarter_sine(g, TABLE_ADDR_BITS);
      assign sine_rom[g] = ENTRY;
   end

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [31:0] cfg_inc_ff,   cfg_inc_in;
   logic [5:0]  cfg_bits_ff,  cfg_bits_in;
   logic [2:0]  cfg_cont_ff,  cfg_cont_in;
   logic        cfg_big_ff,   cfg_big_in;
   logic        cfg_uns_ff,   cfg_uns_in;
   logic [3:0]  cfg_chans_ff, cfg_chans_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_inc_in   = cfg_inc_ff;
      cfg_bits_in  = cfg_bits_ff;
      cfg_cont_in  = cfg_cont_ff;
      cfg_big_in   = cfg_big_ff;
      cfg_uns_in   = cfg_uns_ff;
      cfg_chans_in = cfg_chans_ff;
      if (csr_valid) begin
         case (csr_index)
            pstg_pkg::CSR_PHASE_INCREMENT: cfg_inc_in   = csr_data;
            pstg_pkg::CSR_SAMPLE_BITS:     cfg_bits_in  = csr_data[5:0];
            pstg_pkg::CSR_CONTAINER_BYTES: cfg_cont_in  = csr_data[2:0];
            pstg_pkg::CSR_BIG_ENDIAN:      cfg_big_in   = csr_data[0];
            pstg_pkg::CSR_UNSIGNED_OFFSET: cfg_uns_in   = csr_data[0];
            pstg_pkg::CSR_CHANNEL_COUNT:   cfg_chans_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_inc_ff   <= pstg_pkg::PHASE_INCREMENT_RESET;
         cfg_bits_ff  <= pstg_pkg::SAMPLE_BITS_RESET;
         cfg_cont_ff  <= pstg_pkg::CONTAINER_BYTES_RESET;
         cfg_big_ff   <= pstg_pkg::BIG_ENDIAN_RESET;
         cfg_uns_ff   <= pstg_pkg::UNSIGNED_OFFSET_RESET;
         cfg_chans_ff <= pstg_pkg::CHANNEL_COUNT_RESET;
      end else begin
         cfg_inc_ff   <= cfg_inc_in;
         cfg_bits_ff  <= cfg_bits_in;
         cfg_cont_ff  <= cfg_cont_in;
         cfg_big_ff   <= cfg_big_in;
         cfg_uns_ff   <= cfg_uns_in;
         cfg_chans_ff <= cfg_chans_in;
      end
   end

   // ---------------------------------------------------------------------
   // Decoded configuration (user holds it static while frames are in flight)
   // ---------------------------------------------------------------------
   logic [2:0]  bytes_per_sample;  // 1..4
   logic [2:0]  phys_bytes;        // 1..4
   logic [2:0]  n_bytes;
   logic [30:0] max_val;           // 2^(bits-1) - 1
   logic [31:0] word_mask;
   logic [31:0] sign_bit;
   logic [3:0]  chans_m1;          // channels per frame minus one

   always_comb begin
      // sample width: clamp to 8..32, round down to whole bytes
      if (cfg_bits_ff < 6'd8) begin
         bytes_per_sample = 3'd1;
      end else if (cfg_bits_ff >= 6'd32) begin
         bytes_per_sample = 3'd4;
      end else begin
         bytes_per_sample = cfg_bits_ff[5:3];
      end

      if (cfg_cont_ff == 3'd0) begin
         phys_bytes = 3'd1;
      end else if (cfg_cont_ff > 3'd4) begin
         phys_bytes = 3'd4;
      end else begin
         phys_bytes = cfg_cont_ff;
      end

      n_bytes = (bytes_per_sample < phys_bytes) ? bytes_per_sample : phys_bytes;

      case (bytes_per_sample)
         3'd1: begin
            max_val   = 31'h0000_007F;
            word_mask = 32'h0000_00FF;
            sign_bit  = 32'h0000_0080;
         end
         3'd2: begin
            max_val   = 31'h0000_7FFF;
            word_mask = 32'h0000_FFFF;
            sign_bit  = 32'h0000_8000;
         end
         3'd3: begin
            max_val   = 31'h007F_FFFF;
            word_mask = 32'h00FF_FFFF;
            sign_bit  = 32'h0080_0000;
         end
         default: begin
            max_val   = 31'h7FFF_FFFF;
            word_mask = 32'hFFFF_FFFF;
            sign_bit  = 32'h8000_0000;
         end
      endcase

      if (cfg_chans_ff == 4'd0) begin
         chans_m1 = 4'd0;
      end else if (5'(cfg_chans_ff) > 5'(MAX_CHANNELS)) begin
         chans_m1 = 4'(MAX_CHANNELS - 1);
      end else begin
         chans_m1 = cfg_chans_ff - 4'd1;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: B = ROM read, C = multiply, D = output
   // ---------------------------------------------------------------------
   logic b_valid_ff, b_valid_in;
   logic c_valid_ff, c_valid_in;
   logic d_valid_ff, d_valid_in;
   logic d_free, c_free, b_free;
   logic tick_take;
   logic frame_done;

   logic [CH_W-1:0] chan_ff, chan_in;

   assign rsp_last   = (5'(chan_ff) == 5'(chans_m1));
   assign frame_done = rsp_ready && rsp_last;
   assign d_free     = !d_valid_ff || frame_done;
   assign c_free     = !c_valid_ff || d_free;
   assign b_free     = !b_valid_ff || c_free;
   assign req_ready  = b_free;
   assign tick_take  = req_valid && b_free && req_frame_tick;

   assign b_valid_in = b_free ? tick_take  : b_valid_ff;
   assign c_valid_in = c_free ? b_valid_ff : c_valid_ff;
   assign d_valid_in = d_free ? c_valid_ff : d_valid_ff;

   // ---------------------------------------------------------------------
   // Phase accumulator and ROM addressing
   // ---------------------------------------------------------------------
   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic [PHASE_BITS+31:0]     inc_ext;
   logic [1:0]                 quadrant;
   logic [TABLE_ADDR_BITS-1:0] tab_addr;
   logic [TABLE_ADDR_BITS-1:0] rom_idx;

   assign inc_ext  = {{PHASE_BITS{1'b0}}, cfg_inc_ff};
   assign phase_in = tick_take ? (phase_ff + inc_ext[PHASE_BITS-1:0]) : phase_ff;
   assign quadrant = phase_ff[PHASE_BITS-1 -: 2];
   assign tab_addr = phase_ff[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   // odd quadrants run the table backwards
   assign rom_idx  = quadrant[0] ? (TABLE_ADDR_BITS'(0) - tab_addr) : tab_addr;

   // Stage B payload
   logic [30:0] rom_q_ff, rom_q_in;
   logic        b_peak_ff, b_peak_in;
   logic        b_neg_ff, b_neg_in;

   assign rom_q_in  = tick_take ? sine_rom[rom_idx] : rom_q_ff;
   // odd quadrant at address zero is the crest, one step past the table
   assign b_peak_in = tick_take ? (quadrant[0] && (tab_addr == '0)) : b_peak_ff;
   assign b_neg_in  = tick_take ? quadrant[1] : b_neg_ff;

   // ---------------------------------------------------------------------
   // Stage C: scale magnitude to the sample range
   // ---------------------------------------------------------------------
   logic [31:0] mag;
   logic [61:0] product;
   logic [30:0] scaled_ff, scaled_in;
   logic        c_neg_ff, c_neg_in;
   logic        c_load;

   assign c_load    = c_free && b_valid_ff;
   assign mag       = b_peak_ff ? 32'h8000_0000 : {1'b0, rom_q_ff};
   assign product   = 62'(mag) * 62'(max_val);
   assign scaled_in = c_load ? product[61:31] : scaled_ff;
   assign c_neg_in  = c_load ? b_neg_ff : c_neg_ff;

   // ---------------------------------------------------------------------
   // Stage D: format into the container and fan out per channel
   // ---------------------------------------------------------------------
   logic [31:0] signed_res;
   logic [31:0] coded_res;
   logic [31:0] packed_word;
   logic [3:0]  packed_be;
   logic [31:0] word_ff, word_in;
   logic [3:0]  be_ff, be_in;
   logic        d_load;

   assign d_load = d_free && c_valid_ff;

   always_comb begin
      logic [1:0] pos;
      signed_res  = c_neg_ff ? (32'd0 - {1'b0, scaled_ff}) : {1'b0, scaled_ff};
      coded_res   = signed_res & word_mask;
      if (cfg_uns_ff) begin
         coded_res = coded_res ^ sign_bit;
      end
      packed_word = '0;
      packed_be   = '0;
      pos         = '0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < n_bytes) begin
            pos = cfg_big_ff ? 2'(phys_bytes - 3'd1 - 3'(i)) : 2'(i);
            packed_word[{pos, 3'b000} +: 8] = coded_res[8 * i +: 8];
            packed_be[pos] = 1'b1;
         end
      end
   end

   assign word_in = d_load ? packed_word : word_ff;
   assign be_in   = d_load ? packed_be : be_ff;

   always_comb begin
      chan_in = chan_ff;
      if (d_load) begin
         chan_in = '0;
      end else if (d_valid_ff && rsp_ready && !rsp_last) begin
         chan_in = chan_ff + CH_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_BITS'(1) << (PHASE_BITS - 2);
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         chan_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         chan_ff    <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff  <= rom_q_in;
      b_peak_ff <= b_peak_in;
      b_neg_ff  <= b_neg_in;
      scaled_ff <= scaled_in;
      c_neg_ff  <= c_neg_in;
      word_ff   <= word_in;
      be_ff     <= be_in;
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   logic [CH_W+2:0] chan_ext;

   assign chan_ext        = {3'b000, chan_ff};
   assign rsp_valid       = d_valid_ff;
   assign rsp_channel     = chan_ext[2:0];
   assign rsp_sample_word = word_ff;
   assign rsp_byte_enable = be_ff;

endmodule

[design/pstg_checker.sv]
// Port-level checker for the PCM sine tone generator, bound to the top level.
// Depends on pcm_sine_tone_generator_unit_macros.svh.
`include "pcm_sine_tone_generator_unit_macros.svh"

module pstg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_channel,
   input logic [31:0] rsp_sample_word,
   input logic [3:0]  rsp_byte_enable,
   input logic        rsp_last
);

   // a stalled result holds
   `PSTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_word) && $stable(rsp_channel) && $stable(rsp_last), "rsp payload changed while stalled")

   // within a frame the next channel follows at once with the same word
   `PSTG_ASSERT_NEXT(a_frame_step, rsp_valid && rsp_ready && !rsp_last, rsp_valid && (rsp_channel == 3'($past(rsp_channel) + 3'd1)) && $stable(rsp_sample_word) && $stable(rsp_byte_enable), "frame channel sequence broken")

   // a new frame starts at channel zero
   `PSTG_ASSERT_NEXT(a_frame_start, rsp_valid && rsp_ready && rsp_last, !rsp_valid || (rsp_channel == 3'd0), "frame did not start at channel zero")

   // bytes without an enable are zero, and at least one byte is enabled
   `PSTG_ASSERT_NOW(a_byte_mask, rsp_valid, (rsp_byte_enable != 4'd0) && (rsp_byte_enable[0] || (rsp_sample_word[7:0] == 8'd0)) && (rsp_byte_enable[1] || (rsp_sample_word[15:8] == 8'd0)) && (rsp_byte_enable[2] || (rsp_sample_word[23:16] == 8'd0)) && (rsp_byte_enable[3] || (rsp_sample_word[31:24] == 8'd0)), "disabled byte carries data")

endmodule

bind pcm_sine_tone_generator_unit pstg_checker u_pstg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_channel     (rsp_channel),
   .rsp_sample_word (rsp_sample_word),
   .rsp_byte_enable (rsp_byte_enable),
   .rsp_last        (rsp_last)
);

[tb/pcm_sine_tone_generator_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for pcm_sine_tone_generator_unit: directed and random frame
// ticks over many register settings, every sample transfer checked against a predictor.
// Depends on pstg_pkg and the pcm_sine_tone_generator_unit sources.

module pcm_sine_tone_generator_unit_test;
   import pstg_pkg::*;

   // Predictor constants, at the block's default parameters
   localparam int unsigned ROM_ADDR_BITS = 10;
   localparam int unsigned ROM_DEPTH     = 1 << ROM_ADDR_BITS;
   localparam logic [63:0] PI_HALF_Q31   = 64'd3373259426;
   localparam logic [63:0] Q31_UNITY     = 64'd2147483648;
   localparam longint      Q31_CEILING   = 64'sd2147483647;
   localparam int unsigned MAX_LANES     = 8;

   // Indexes past the register list; the block drops writes to them
   localparam csr_index_type CSR_SPARE_LOW  = 3'd6;
   localparam csr_index_type CSR_SPARE_HIGH = 3'd7;

   // Quiet cycles after the last sample before a register write or the end.
   // Pipeline is three deep; zero ticks never enter it.
   localparam int unsigned QUIET_CYCLES = 12;
   // Long receiver hold-off, enough to back the pipeline up into req_ready
   localparam int unsigned LONG_HOLD    = 150;
   // Worst case is 8 samples per tick, each behind a receiver stall, plus the
   // sender gap, for ~130 ticks; this is several times that.
   localparam int unsigned CYCLE_LIMIT  = 300000;

   typedef struct packed {
      logic [2:0]  channel;
      logic [31:0] sample_word;
      logic [3:0]  byte_enable;
      logic        last;
   } tone_sample_type;

   // Tracks phase and registers, builds the samples each tick should produce
   // and checks rsp_ transfers against them in order.
   class tone_frame_scoreboard;
      logic [30:0]     quarter_rom [ROM_DEPTH];
      logic [31:0]     phase;
      logic [31:0]     step;
      logic [5:0]      width_reg;
      logic [2:0]      slot_reg;
      logic            msb_first;
      logic            offset_binary;
      logic [3:0]      lane_reg;
      tone_sample_type samples_due [$];
      int unsigned     mismatches;

      function new();
         for (int i = 0; i < ROM_DEPTH; i++) begin
            quarter_rom[i] = quarter_wave(i);
         end
         phase         = 32'h4000_0000;
         step          = PHASE_INCREMENT_RESET;
         width_reg     = SAMPLE_BITS_RESET;
         slot_reg      = CONTAINER_BYTES_RESET;
         msb_first     = BIG_ENDIAN_RESET;
         offset_binary = UNSIGNED_OFFSET_RESET;
         lane_reg      = CHANNEL_COUNT_RESET;
         mismatches    = 0;
      endfunction

      // Truncated Taylor series for sin(pi/2 * i / depth) in Q31
      function logic [30:0] quarter_wave(int unsigned i);
         logic [63:0] x;
         logic [63:0] x_sq;
         logic [63:0] term;
         longint      acc;
         x    = (64'(i) * PI_HALF_Q31) >> ROM_ADDR_BITS;
         x_sq = (x * x) >> 31;
         term = x;
         acc  = longint'(x);
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x_sq) >> 31) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > Q31_CEILING) begin
            acc = Q31_CEILING;
         end
         return 31'(acc);
      endfunction

      function void write_register(csr_index_type index, logic [31:0] data);
         case (index)
            CSR_PHASE_INCREMENT: step          = data;
            CSR_SAMPLE_BITS:     width_reg     = data[5:0];
            CSR_CONTAINER_BYTES: slot_reg      = data[2:0];
            CSR_BIG_ENDIAN:      msb_first     = data[0];
            CSR_UNSIGNED_OFFSET: offset_binary = data[0];
            CSR_CHANNEL_COUNT:   lane_reg      = data[3:0];
            default: ;
         endcase
      endfunction

      // One accepted req_ transfer: for a tick of one, queue the frame's samples, then step phase
      function void accept_tick(logic tick);
         logic [1:0]      quadrant;
         logic [9:0]      addr;
         logic [9:0]      mirror_addr;
         logic [63:0]     mag;
         logic [63:0]     full_scale;
         logic [63:0]     scaled;
         logic [63:0]     value;
         int unsigned     nbits;
         int unsigned     slot;
         int unsigned     used;
         int unsigned     lanes;
         int unsigned     pos;
         logic [31:0]     word;
         logic [3:0]      enables;
         tone_sample_type s;
         if (!tick) begin
            return;
         end
         quadrant    = phase[31:30];
         addr        = phase[29:20];
         mirror_addr = 10'd0 - addr;
         if (quadrant[0]) begin
            mag = (addr == 0) ? Q31_UNITY : 64'(quarter_rom[mirror_addr]);
         end else begin
            mag = 64'(quarter_rom[addr]);
         end

         // width clamps to 8..32, then down to whole bytes
         nbits = width_reg;
         if (nbits < 8) begin
            nbits = 8;
         end
         if (nbits > 32) begin
            nbits = 32;
         end
         nbits = nbits - (nbits % 8);

         full_scale = (64'd1 << (nbits - 1)) - 64'd1;
         scaled     = (mag * full_scale) >> 31;
         value      = quadrant[1] ? (64'd0 - scaled) : scaled;
         value      = value & ((64'd1 << nbits) - 64'd1);
         if (offset_binary) begin
            value = value ^ (64'd1 << (nbits - 1));
         end

         slot = slot_reg;
         if (slot < 1) begin
            slot = 1;
         end
         if (slot > 4) begin
            slot = 4;
         end
         used    = (nbits / 8 < slot) ? nbits / 8 : slot;
         word    = '0;
         enables = '0;
         for (int i = 0; i < used; i++) begin
            pos     = msb_first ? slot - 1 - i : i;
            word    = word | (32'(value[8 * i +: 8]) << (8 * pos));
            enables = enables | 4'(1 << pos);
         end

         lanes = lane_reg;
         if (lanes < 1) begin
            lanes = 1;
         end
         if (lanes > MAX_LANES) begin
            lanes = MAX_LANES;
         end
         for (int c = 0; c < lanes; c++) begin
            s.channel     = 3'(c);
            s.sample_word = word;
            s.byte_enable = enables;
            s.last        = (c == lanes - 1);
            samples_due.push_back(s);
         end
         phase = phase + step;
      endfunction

      function void check_sample(tone_sample_type got);
         tone_sample_type want;
         if (samples_due.size() == 0) begin
            $error("sample transfer with none due: channel %0d word %h",
                   got.channel, got.sample_word);
            mismatches++;
            return;
         end
         want = samples_due.pop_front();
         if (got.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, got.channel);
            mismatches++;
         end
         if (got.sample_word !== want.sample_word) begin
            $error("sample_word: expected %h, got %h", want.sample_word, got.sample_word);
            mismatches++;
         end
         if (got.byte_enable !== want.byte_enable) begin
            $error("byte_enable: expected %b, got %b", want.byte_enable, got.byte_enable);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT and its connections; every input known from time zero
   // ---------------------------------------------------------------------
   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_ready;
   logic          req_frame_tick = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready      = 1'b0;
   logic [2:0]    rsp_channel;
   logic [31:0]   rsp_sample_word;
   logic [3:0]    rsp_byte_enable;
   logic          rsp_last;
   logic          csr_valid      = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index      = CSR_PHASE_INCREMENT;
   logic [31:0]   csr_data       = '0;

   pcm_sine_tone_generator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_frame_tick  (req_frame_tick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel     (rsp_channel),
      .rsp_sample_word (rsp_sample_word),
      .rsp_byte_enable (rsp_byte_enable),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   tone_frame_scoreboard tones = new();

   // Knobs the stimulus turns per phase; read by the drivers
   int unsigned req_gap_max     = 12;  // sender idle cycles per item, 0..max
   int unsigned rsp_stall_max   = 12;  // receiver stall cycles per sample, 0..max
   int unsigned rsp_hold_cycles = 0;   // one-shot long hold-off request

   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run here
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL pcm_sine_tone_generator_unit");
         $finish;
      end
   end

   // Sample monitor: a transfer is seen at the rising edge with valid and ready high.
   // Values read here are the ones settled before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tones.check_sample(tone_sample_type'{rsp_channel, rsp_sample_word,
                                              rsp_byte_enable, rsp_last});
      end
   end

   // Sample receiver: random stall before each transfer, or the long hold-off
   // when the stimulus asks for it. Counts its own cycles at falling edges.
   initial begin : sample_sink
      int unsigned stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(rsp_stall_max, 0);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // One req_ transfer. Entered and left at a falling edge. With no gap, valid
   // stays high straight into the next item, so it is never lowered and
   // raised in one step.
   task automatic send_tick(logic tick);
      int unsigned gap;
      gap = $urandom_range(req_gap_max, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_frame_tick <= tick;
      do @(posedge clock); while (req_ready !== 1'b1);
      tones.accept_tick(tick);
      @(negedge clock);
   endtask

   // Stop offering and wait for every due sample
   task automatic drain_samples();
      req_valid <= 1'b0;
      while (tones.samples_due.size() != 0) @(negedge clock);
   endtask

   // Idle point for register writes: drained, then quiet cycles
   task automatic settle();
      drain_samples();
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // One csr_ transfer; csr_valid is left high for back-to-back writes
   task automatic write_csr(csr_index_type index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tones.write_register(index, data);
      @(negedge clock);
   endtask

   // Full register setting, plus a stray write past the register list.
   // Upper data bits get random filler; the block must ignore them.
   task automatic program_tone(logic [31:0] increment, logic [5:0] nbits,
                               logic [2:0] slot, logic msb, logic offset,
                               logic [3:0] lanes);
      write_csr(CSR_SAMPLE_BITS,     {26'($urandom_range(32'h03FF_FFFF, 0)), nbits});
      write_csr(CSR_CONTAINER_BYTES, {29'($urandom_range(32'h1FFF_FFFF, 0)), slot});
      write_csr(CSR_BIG_ENDIAN,      {31'($urandom_range(32'h7FFF_FFFF, 0)), msb});
      write_csr(CSR_UNSIGNED_OFFSET, {31'($urandom_range(32'h7FFF_FFFF, 0)), offset});
      write_csr(CSR_CHANNEL_COUNT,   {28'($urandom_range(32'h0FFF_FFFF, 0)), lanes});
      write_csr($urandom_range(1, 0) ? CSR_SPARE_HIGH : CSR_SPARE_LOW, $urandom());
      write_csr(CSR_PHASE_INCREMENT, increment);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] increment;
      logic [5:0]  nbits;
      logic [2:0]  slot;
      logic [3:0]  lanes;

      // Synchronous reset held from time zero, released at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- Directed ---
      // Quarter-turn steps from the reset phase land exactly on each quadrant
      // start: positive peak, negative zero, negative peak, zero. 32-bit
      // samples, full container, all eight channels.
      program_tone(32'h4000_0000, 6'd32, 3'd4, 1'b0, 1'b0, 4'd8);
      repeat (4) send_tick(1'b1);
      send_tick(1'b0);   // ignored, phase must hold
      send_tick(1'b1);

      // Same phases, 8-bit offset-binary placed big-endian in 4 bytes, one channel
      settle();
      program_tone(32'h4000_0000, 6'd8, 3'd4, 1'b1, 1'b1, 4'd1);
      repeat (4) send_tick(1'b1);

      // Out-of-range low settings: width 0, container 0, channel count 0
      settle();
      program_tone(32'hFFFF_FFFF, 6'd0, 3'd0, 1'b0, 1'b1, 4'd0);
      repeat (2) send_tick(1'b1);

      // Out-of-range high settings, zero step
      settle();
      program_tone(32'h0000_0000, 6'd63, 3'd7, 1'b1, 1'b0, 4'd15);
      repeat (2) send_tick(1'b1);

      // Odd width rounds down; 16-bit sample truncated into a 1-byte container
      settle();
      program_tone(32'h0123_4567, 6'd20, 3'd1, 1'b1, 1'b0, 4'd3);
      repeat (2) send_tick(1'b1);

      // 24-bit sample into 2 bytes, channel count past the maximum
      settle();
      program_tone(32'h1234_5678, 6'd24, 3'd2, 1'b0, 1'b1, 4'd9);
      repeat (2) send_tick(1'b1);

      // Back to the reset setting
      settle();
      program_tone(PHASE_INCREMENT_RESET, SAMPLE_BITS_RESET, CONTAINER_BYTES_RESET,
                   BIG_ENDIAN_RESET, UNSIGNED_OFFSET_RESET, CHANNEL_COUNT_RESET);
      repeat (2) send_tick(1'b1);

      // --- Random phases: new setting each, mostly legal values ---
      for (int p = 0; p < 8; p++) begin
         settle();
         increment = $urandom_range(1, 0) ? $urandom() : $urandom_range(32'h00FF_FFFF, 0);
         nbits     = ($urandom_range(3, 0) == 0) ? 6'($urandom_range(63, 0))
                                                 : 6'(8 * $urandom_range(4, 1));
         slot      = ($urandom_range(3, 0) == 0) ? 3'($urandom_range(7, 0))
                                                 : 3'($urandom_range(4, 1));
         lanes     = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0))
                                                 : 4'($urandom_range(8, 1));
         program_tone(increment, nbits, slot, 1'($urandom_range(1, 0)),
                      1'($urandom_range(1, 0)), lanes);

         // Some phases run flat out on one side or the other
         req_gap_max   = (p % 3 == 0) ? 0 : 12;
         rsp_stall_max = (p % 4 == 1) ? 0 : 12;
         if (p == 5) begin
            // Receiver holds off while ticks keep coming: pipeline fills and
            // req_ready must drop
            req_gap_max     = 0;
            rsp_hold_cycles = LONG_HOLD;
         end

         for (int j = 0; j < 14; j++) begin
            if (p == 6 && j == 8) begin
               // sender pause until every sample has come out
               drain_samples();
            end
            send_tick($urandom_range(9, 0) != 0);
         end
      end

      settle();
      if (tones.mismatches == 0 && tones.samples_due.size() == 0) begin
         $display("PASS pcm_sine_tone_generator_unit");
      end else begin
         $display("FAIL pcm_sine_tone_generator_unit");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/pstg_pkg.sv
design/pcm_sine_tone_generator_unit.sv
design/pstg_checker.sv
tb/pcm_sine_tone_generator_unit_test.sv
